@@ src/text_console_writer_defines.svh @@
// Assertion macros for the checker file of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define TCW_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tcw_pkg.sv @@
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = CHAR_W + ATTR_W;
    localparam int FIELD_COL_W = 7;
    localparam int FIELD_ROW_W = 5;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT      = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_READ       = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_FINISH
    } state_t;

endpackage

@@ src/tcw_req_if.sv @@
interface tcw_req_if import tcw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [CHAR_W-1:0]      char_code;
    logic [FIELD_COL_W-1:0] column;
    logic [FIELD_ROW_W-1:0] row;

    modport source (output valid, command, char_code, column, row, input ready);
    modport sink   (input valid, command, char_code, column, row, output ready);
endinterface

@@ src/tcw_rsp_if.sv @@
interface tcw_rsp_if import tcw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_COL_W-1:0] cursor_column;
    logic [FIELD_ROW_W-1:0] cursor_row;
    logic [CHAR_W-1:0]      cell_char;
    logic [ATTR_W-1:0]      cell_attr;
    logic                   scrolled;

    modport source (output valid, cursor_column, cursor_row, cell_char, cell_attr, scrolled,
                    input ready);
    modport sink   (input valid, cursor_column, cursor_row, cell_char, cell_attr, scrolled,
                    output ready);
endinterface

@@ src/tcw_cfg_if.sv @@
interface tcw_cfg_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attribute;

    modport source (output valid, text_attribute, input ready);
    modport sink   (input valid, text_attribute, output ready);
endinterface

@@ src/tcw_cell_mem.sv @@
module tcw_cell_mem import tcw_pkg::*; #(
    parameter int DEPTH  = COLUMNS_DEFAULT * ROWS_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem_array [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    // one write port, one registered read port; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/text_console_writer.sv @@
// Text-mode console of COLUMNS x ROWS cells (80 x 25 by default), each cell a character
// byte with an attribute byte above it, kept in one synchronous memory with one write
// port and one registered read port.
// Commands on req: print a character (newline moves to column 0 of the next row, any
// other byte is stored with the current attribute and the cursor advances with wrap),
// set the cursor (saturated to the last column and row), and read a cell (address
// saturated the same way). Each transfer on req gives exactly one transfer on rsp with
// the cursor after the command, the cell read (zero for other commands) and a scroll
// flag. The attribute register on cfg resets to 0x0F and may be written at any time the
// block is idle. After reset the block runs a clearing pass over all COLUMNS*ROWS cells
// (2000 by default) that zeroes the memory, with req.ready low. Set cursor, read cell
// and a print that does not scroll transfer the command and access the memory in idle,
// then load the result register in the finish state once rsp is free. A print that
// moves below the last row first runs the scroll sweep, which moves one cell per cycle
// through the memory's read and write ports. The result register lets the next command
// transfer while the previous result still waits on rsp.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp,
    tcw_cfg_if.sink   cfg
);

    localparam int CELLS       = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int CUR_COL_W   = $clog2(COLUMNS);
    localparam int CUR_ROW_W   = $clog2(ROWS);
    localparam int SHIFT_CELLS = CELLS - COLUMNS;

    localparam logic [CUR_COL_W-1:0] COL_LAST   = CUR_COL_W'(COLUMNS - 1);
    localparam logic [CUR_ROW_W-1:0] ROW_LAST   = CUR_ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0]    ADDR_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0]    SHIFT_END  = ADDR_W'(SHIFT_CELLS);
    localparam logic [ADDR_W-1:0]    ROW_STRIDE = ADDR_W'(COLUMNS);

    // control state
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      cnt_reg, cnt_next;
    logic [CUR_COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [CUR_ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [ATTR_W-1:0]      attr_reg;
    logic                   wb_valid_reg, wb_valid_next;
    logic                   out_valid_reg, out_valid_next;

    // payload held across the item
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic                   scrolled_reg, scrolled_next;
    logic [ADDR_W-1:0]      wb_addr_reg, wb_addr_next;
    logic                   wb_space_reg, wb_space_next;
    logic [FIELD_COL_W-1:0] out_col_reg, out_col_next;
    logic [FIELD_ROW_W-1:0] out_row_reg, out_row_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic [ATTR_W-1:0]      out_attr_reg, out_attr_next;
    logic                   out_scrolled_reg, out_scrolled_next;

    // memory port
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [CELL_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [CELL_W-1:0]      mem_rdata;

    logic                   accept;
    logic                   out_load;
    logic                   line_end;
    logic                   will_scroll;
    logic [CUR_COL_W-1:0]   col_sat;
    logic [CUR_ROW_W-1:0]   row_sat;
    logic [ADDR_W-1:0]      cur_addr;
    logic [ADDR_W-1:0]      sat_addr;

    tcw_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshakes: commands only in idle, configuration always.
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    // Saturate the requested position to the last column and row.
    always_comb
    begin
        if (int'(req.column) > COLUMNS - 1)
        begin
            col_sat = COL_LAST;
        end
        else
        begin
            col_sat = CUR_COL_W'(req.column);
        end
        if (int'(req.row) > ROWS - 1)
        begin
            row_sat = ROW_LAST;
        end
        else
        begin
            row_sat = CUR_ROW_W'(req.row);
        end
    end

    assign cur_addr = ADDR_W'(cur_row_reg) * ROW_STRIDE + ADDR_W'(cur_col_reg);
    assign sat_addr = ADDR_W'(row_sat) * ROW_STRIDE + ADDR_W'(col_sat);

    // A newline or a character in the last column ends the line; on the last row
    // that scrolls the screen.
    assign line_end    = (req.char_code == NEWLINE_CODE) || (cur_col_reg == COL_LAST);
    assign will_scroll = (req.command == CMD_PRINT) && line_end && (cur_row_reg == ROW_LAST);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = will_scroll ? ST_SCROLL : ST_FINISH;
                end
            end
            ST_SCROLL:
            begin
                if (cnt_reg == ADDR_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        cnt_next          = cnt_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        cmd_next          = cmd_reg;
        scrolled_next     = scrolled_reg;
        wb_valid_next     = 1'b0;
        wb_addr_next      = wb_addr_reg;
        wb_space_next     = wb_space_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        out_char_next     = out_char_reg;
        out_attr_next     = out_attr_reg;
        out_scrolled_next = out_scrolled_reg;
        mem_we            = 1'b0;
        mem_waddr         = cnt_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = sat_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero one cell a cycle
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
                cnt_next  = (cnt_reg == ADDR_LAST) ? '0 : cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = req.command;
                    scrolled_next = will_scroll;
                    unique case (req.command)
                        CMD_PRINT:
                        begin
                            if (req.char_code != NEWLINE_CODE)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {attr_reg, req.char_code};
                            end
                            if (line_end)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg != ROW_LAST)
                                begin
                                    cur_row_next = cur_row_reg + CUR_ROW_W'(1);
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + CUR_COL_W'(1);
                            end
                        end
                        CMD_SET_CURSOR:
                        begin
                            cur_col_next = col_sat;
                            cur_row_next = row_sat;
                        end
                        CMD_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = sat_addr;
                        end
                        default:
                        begin
                            // unused command: no change
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // read the cell one row below, write it back in the next cycle;
                // the bottom row gets spaces instead
                mem_re        = (cnt_reg < SHIFT_END);
                mem_raddr     = cnt_reg + ROW_STRIDE;
                wb_valid_next = 1'b1;
                wb_addr_next  = cnt_reg;
                wb_space_next = (cnt_reg >= SHIFT_END);
                cnt_next      = (cnt_reg == ADDR_LAST) ? '0 : cnt_reg + ADDR_W'(1);
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    out_col_next      = FIELD_COL_W'(cur_col_reg);
                    out_row_next      = FIELD_ROW_W'(cur_row_reg);
                    out_char_next     = (cmd_reg == CMD_READ) ? mem_rdata[CHAR_W-1:0] : '0;
                    out_attr_next     = (cmd_reg == CMD_READ) ? mem_rdata[CELL_W-1:CHAR_W] : '0;
                    out_scrolled_next = scrolled_reg;
                end
            end
            default:
            begin
            end
        endcase

        // scroll write-back stage; never coincides with a print write
        if (wb_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_reg;
            mem_wdata = wb_space_reg ? {attr_reg, SPACE_CODE} : mem_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            attr_reg      <= ATTR_RESET;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                attr_reg <= cfg.text_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        scrolled_reg     <= scrolled_next;
        wb_addr_reg      <= wb_addr_next;
        wb_space_reg     <= wb_space_next;
        out_col_reg      <= out_col_next;
        out_row_reg      <= out_row_next;
        out_char_reg     <= out_char_next;
        out_attr_reg     <= out_attr_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_column = out_col_reg;
    assign rsp.cursor_row    = out_row_reg;
    assign rsp.cell_char     = out_char_reg;
    assign rsp.cell_attr     = out_attr_reg;
    assign rsp.scrolled      = out_scrolled_reg;

endmodule

@@ src/tcw_checker.sv @@
`include "text_console_writer_defines.svh"

module tcw_checker import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp
);

    // one command in flight: a transfer drops ready in the next cycle
    `TCW_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req.valid && req.ready, !req.ready, "command taken while busy")

    // the cursor always names a cell on screen
    `TCW_ASSERT_SAME(a_cursor_range, clk, rst_n, rsp.valid, (rsp.cursor_column <= 7'(COLUMNS - 1)) && (rsp.cursor_row <= 5'(ROWS - 1)), "cursor off screen")

    // a scroll leaves the cursor at the start of the bottom row
    `TCW_ASSERT_SAME(a_scroll_cursor, clk, rst_n, rsp.valid && rsp.scrolled, (rsp.cursor_column == 7'd0) && (rsp.cursor_row == 5'(ROWS - 1)), "scroll left cursor away from bottom row")

    // a stalled result holds
    `TCW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.cursor_column) && $stable(rsp.cursor_row) && $stable(rsp.cell_char) && $stable(rsp.cell_attr) && $stable(rsp.scrolled), "stalled result changed")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

@@ test/text_console_checker.sv @@
module text_console_checker import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    tcw_req_if   req,
    tcw_rsp_if   rsp,
    tcw_cfg_if   cfg,
    output int   failures,
    output int   outstanding
);

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] chr;
    } glyph_t;

    typedef struct packed {
        logic [FIELD_COL_W-1:0] cursor_column;
        logic [FIELD_ROW_W-1:0] cursor_row;
        logic [CHAR_W-1:0]      cell_char;
        logic [ATTR_W-1:0]      cell_attr;
        logic                   scrolled;
    } console_status_t;

    glyph_t            screen [COLUMNS*ROWS];
    int                cursor_col;
    int                cursor_row;
    logic [ATTR_W-1:0] text_attr;
    console_status_t   status_queue [$];
    console_status_t   want;

    function automatic int saturate(int v, int top);
        return (v > top) ? top : v;
    endfunction

    // Move to the start of the next row; scroll the screen up when past the bottom.
    function automatic logic next_row();
        cursor_col = 0;
        cursor_row++;
        if (cursor_row < ROWS)
            return 1'b0;
        cursor_row = ROWS - 1;
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int c = 0; c < COLUMNS; c++)
            screen[(ROWS - 1) * COLUMNS + c] = '{attr: text_attr, chr: SPACE_CODE};
        return 1'b1;
    endfunction

    function automatic console_status_t apply_command(
        logic [CMD_W-1:0]       cmd,
        logic [CHAR_W-1:0]      code,
        logic [FIELD_COL_W-1:0] col,
        logic [FIELD_ROW_W-1:0] row
    );
        console_status_t s;
        glyph_t          g;
        int              c;
        int              r;
        s = '0;
        case (cmd)
            CMD_PRINT:
                if (code == NEWLINE_CODE)
                    s.scrolled = next_row();
                else
                begin
                    screen[cursor_row * COLUMNS + cursor_col] = '{attr: text_attr, chr: code};
                    cursor_col++;
                    if (cursor_col >= COLUMNS)
                        s.scrolled = next_row();
                end
            CMD_SET_CURSOR:
            begin
                cursor_col = saturate(int'(col), COLUMNS - 1);
                cursor_row = saturate(int'(row), ROWS - 1);
            end
            CMD_READ:
            begin
                c = saturate(int'(col), COLUMNS - 1);
                r = saturate(int'(row), ROWS - 1);
                g = screen[r * COLUMNS + c];
                s.cell_char = g.chr;
                s.cell_attr = g.attr;
            end
            default:
                ;
        endcase
        s.cursor_column = FIELD_COL_W'(cursor_col);
        s.cursor_row    = FIELD_ROW_W'(cursor_row);
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int expected_value);
        $display("%0t: %s is %0d, expected %0d", $time, what, got, expected_value);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COLUMNS * ROWS; i++)
                screen[i] = '0;
            cursor_col = 0;
            cursor_row = 0;
            text_attr  = ATTR_RESET;
            status_queue.delete();
            failures    = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (status_queue.size() == 0)
                    report_mismatch("result transfers with none pending", 1, 0);
                else
                begin
                    want = status_queue.pop_front();
                    if (rsp.cursor_column !== want.cursor_column)
                        report_mismatch("cursor_column", rsp.cursor_column, want.cursor_column);
                    if (rsp.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", rsp.cursor_row, want.cursor_row);
                    if (rsp.cell_char !== want.cell_char)
                        report_mismatch("cell_char", rsp.cell_char, want.cell_char);
                    if (rsp.cell_attr !== want.cell_attr)
                        report_mismatch("cell_attr", rsp.cell_attr, want.cell_attr);
                    if (rsp.scrolled !== want.scrolled)
                        report_mismatch("scrolled", rsp.scrolled, want.scrolled);
                end
            end
            if (cfg.valid && cfg.ready)
                text_attr = cfg.text_attribute;
            if (req.valid && req.ready)
                status_queue.push_back(apply_command(req.command, req.char_code,
                                                     req.column, req.row));
            outstanding <= status_queue.size();
        end
    end

endmodule

@@ test/text_console_writer_tb.sv @@
module text_console_writer_tb;
    import tcw_pkg::*;

    // The block leaves command 3 undefined; it must change nothing.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Long receiver hold-off, enough to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 400;
    // A scroll sweep and the clearing pass after reset each go over all 2000
    // cells with no command transfer; the limit is ten times the cell count.
    localparam int STALL_LIMIT     = 20000;
    // Cycles to keep watching after the last result, for any stray transfer.
    localparam int DRAIN_CYCLES    = 20;

    logic clk = 1'b0;
    logic rst_n;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();
    tcw_cfg_if cfg_ch ();

    int failures;
    int outstanding;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int text_col;
    int text_row;
    bit hold_armed;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    text_console_writer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    text_console_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // Result side: take results at random, or hold off for a long stretch when
    // the stimulus arms it. The hold-off is counted here so that the sender
    // keeps offering items the whole time.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_armed = 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if no transfer happens on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one command, idling first at the current sender rate, and hold it
    // until the block takes the transfer. Valid stays high when the next item
    // follows without a gap.
    task automatic send_command(
        logic [CMD_W-1:0]       cmd,
        logic [CHAR_W-1:0]      code,
        logic [FIELD_COL_W-1:0] col,
        logic [FIELD_ROW_W-1:0] row
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.char_code <= code;
        req_ch.column    <= col;
        req_ch.row       <= row;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    // Drop valid and wait until every result has been taken.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Change the attribute only while the block has nothing in flight.
    task automatic write_attribute(logic [ATTR_W-1:0] value);
        drain_results();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.text_attribute <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly printable text, sometimes a newline, now and then any byte.
    function automatic logic [CHAR_W-1:0] text_byte();
        if ($urandom_range(11) == 0)
            return NEWLINE_CODE;
        if ($urandom_range(7) == 0)
            return CHAR_W'($urandom_range(255));
        return CHAR_W'($urandom_range(126, 32));
    endfunction

    // Random traffic in bursts: lines of text at a fresh cursor, read-back of
    // the area just written, text at the bottom row to force scrolls, and
    // unconstrained noise over the full width of every field.
    task automatic random_traffic(int count);
        int first;
        int kind;
        first = items_sent;
        while (items_sent - first < count)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                text_col = $urandom_range(79);
                text_row = $urandom_range(24);
                send_command(CMD_SET_CURSOR, CHAR_W'($urandom_range(255)),
                             FIELD_COL_W'(text_col), FIELD_ROW_W'(text_row));
                repeat ($urandom_range(16, 1))
                    send_command(CMD_PRINT, text_byte(), FIELD_COL_W'($urandom_range(127)),
                                 FIELD_ROW_W'($urandom_range(31)));
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(4, 1))
                    send_command(CMD_READ, CHAR_W'($urandom_range(255)),
                                 FIELD_COL_W'($urandom_range(79)),
                                 FIELD_ROW_W'(text_row + $urandom_range(1)));
            end
            else if (kind < 88)
                send_command(CMD_SET_CURSOR + 2'($urandom_range(3)) - CMD_SET_CURSOR,
                             CHAR_W'($urandom_range(255)), FIELD_COL_W'($urandom_range(127)),
                             FIELD_ROW_W'($urandom_range(31)));
            else
            begin
                text_col = $urandom_range(79, 60);
                text_row = 24;
                send_command(CMD_SET_CURSOR, CHAR_W'($urandom_range(255)),
                             FIELD_COL_W'(text_col), FIELD_ROW_W'(text_row));
                repeat ($urandom_range(24, 1))
                    send_command(CMD_PRINT, text_byte(), FIELD_COL_W'($urandom_range(127)),
                                 FIELD_ROW_W'($urandom_range(31)));
            end
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_PRINT;
        req_ch.char_code      = '0;
        req_ch.column         = '0;
        req_ch.row            = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.text_attribute = ATTR_RESET;
        hold_armed            = 1'b0;
        send_idle_pct         = 0;
        recv_idle_pct         = 0;
        items_sent            = 0;
        text_col              = 0;
        text_row              = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset attribute. The block stalls its
        // input during the clearing pass; the handshake absorbs that.
        // Read the cleared memory, at the origin and at a saturated address.
        send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
        send_command(CMD_READ, 8'hFF, 7'h7F, 5'h1F);
        // Print, then read back character and attribute.
        send_command(CMD_PRINT, 8'h41, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
        // Extreme character bytes.
        send_command(CMD_PRINT, 8'h00, 7'h7F, 5'h1F);
        send_command(CMD_PRINT, 8'hFF, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd2, 5'd0);
        // Saturating set cursor, then a print in the last cell: wrap and scroll.
        send_command(CMD_SET_CURSOR, 8'h00, 7'h7F, 5'h1F);
        send_command(CMD_PRINT, 8'h5A, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd79, 5'd23);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd24);
        send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
        // Newline on the bottom row scrolls too.
        send_command(CMD_PRINT, NEWLINE_CODE, 7'd0, 5'd0);
        // Newline higher up only moves the cursor.
        send_command(CMD_SET_CURSOR, 8'h00, 7'd0, 5'd0);
        send_command(CMD_PRINT, NEWLINE_CODE, 7'd0, 5'd0);
        // Wrap at the end of a line without a scroll.
        send_command(CMD_SET_CURSOR, 8'h00, 7'd78, 5'd3);
        send_command(CMD_PRINT, 8'h78, 7'd0, 5'd0);
        send_command(CMD_PRINT, 8'h79, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd79, 5'd3);
        // Undefined command with every field at its top.
        send_command(CMD_UNUSED, 8'hFF, 7'h7F, 5'h1F);
        // Each coordinate saturating on its own.
        send_command(CMD_SET_CURSOR, 8'h00, 7'd0, 5'h1F);
        send_command(CMD_SET_CURSOR, 8'h00, 7'h7F, 5'd0);
        // Newline from the last cell of the screen.
        send_command(CMD_SET_CURSOR, 8'h00, 7'd79, 5'd24);
        send_command(CMD_PRINT, NEWLINE_CODE, 7'd0, 5'd0);
        send_command(CMD_READ, 8'h00, 7'd79, 5'd24);

        // Sender idles lightly, receiver heavily.
        write_attribute(8'hFF);
        send_idle_pct = 12;
        recv_idle_pct = 69;
        random_traffic(250);

        // The other way round.
        write_attribute(8'h00);
        send_idle_pct = 69;
        recv_idle_pct = 12;
        random_traffic(250);

        // Neither side idles.
        write_attribute(ATTR_W'($urandom_range(255)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(200);

        // Back the block up: hold results off while items keep coming.
        write_attribute(ATTR_W'($urandom_range(255)));
        hold_armed = 1'b1;
        random_traffic(100);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/tcw_pkg.sv
src/tcw_req_if.sv
src/tcw_rsp_if.sv
src/tcw_cfg_if.sv
src/tcw_cell_mem.sv
src/text_console_writer.sv
src/tcw_checker.sv
test/text_console_checker.sv
test/text_console_writer_tb.sv
